/* design/qfaa_pkg.sv */
// qfaa_pkg: widths, request types and small helpers for the quaternion from axis/angle core
// no dependencies; used by qfaa_isqrt, qfaa_div and quaternion_from_axis_angle_core
`timescale 1ns / 1ps

package qfaa_pkg;

    localparam int COMPONENT_BITS = 16;
    localparam int FRAC_BITS      = COMPONENT_BITS - 2;
    localparam int ANGLE_BITS     = 16;

    // raw component magnitudes, units of 2^-(F+15)
    localparam int RAW_W  = COMPONENT_BITS + 15;
    localparam int MAG_W  = 31;
    // common shift runs 0 .. RAW_W - 31, at least one bit wide
    localparam int SH_W   = (RAW_W > 31) ? $clog2(RAW_W - 30) : 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int SUM_W  = 64;
    localparam int ROOT_W = 32;
    localparam int RS_W   = ROOT_W + 2;
    localparam int NUM_W  = MAG_W + FRAC_BITS + 2;
    localparam int Q_W    = FRAC_BITS + 1;

    localparam logic [15:0] POLY_A    = 16'd51472;
    localparam logic [15:0] POLY_B    = 16'd21024;
    localparam logic [15:0] POLY_C    = 16'd2320;
    localparam logic [15:0] Q15_ONE   = 16'd32768;
    localparam logic [31:0] Q15_HALF  = 32'd16384;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] axis_x;
        logic signed [COMPONENT_BITS-1:0] axis_y;
        logic signed [COMPONENT_BITS-1:0] axis_z;
        logic signed [ANGLE_BITS-1:0]     turn_angle;
    } t_in_req;

    typedef struct packed {
        logic signed [COMPONENT_BITS-1:0] quat_w;
        logic signed [COMPONENT_BITS-1:0] quat_x;
        logic signed [COMPONENT_BITS-1:0] quat_y;
        logic signed [COMPONENT_BITS-1:0] quat_z;
        logic                             zero_magnitude;
    } t_out_req;

    // sign flags of the three vector parts
    typedef struct packed {
        logic [2:0] neg;
    } t_div_side;

    // what rides alongside the square root
    typedef struct packed {
        t_div_side             ctl;
        logic [3:0][MAG_W-1:0] mag;
    } t_sqrt_side;

    // (p + 0.5) >> 15 in Q15
    function automatic logic [16:0] rnd15(input logic [31:0] p);
        logic [32:0] s;
        s = {1'b0, p} + {1'b0, Q15_HALF};
        return s[31:15];
    endfunction

endpackage

/* design/quaternion_from_axis_angle_core.sv */
// quaternion_from_axis_angle_core: normalised unit quaternion from axis and binary angle
// depends on qfaa_pkg, qfaa_isqrt and qfaa_div
`timescale 1ns / 1ps

// Takes one request per cycle while not stalled (axis in signed Q1.14, angle as a signed
// 16-bit binary angle) and returns one request per input with w = cos(angle/2), v = axis *
// sin(angle/2), all four parts divided by their joint magnitude and rounded to nearest in
// Q1.14. A zero magnitude gives all zero parts and sets zero_magnitude. Throughput is one
// request per clock while not stalled; the pipeline holds the 32-stage square root and the
// one-bit-per-stage divider. The whole pipeline holds while a finished result waits under
// stall, so o_in_stall follows i_out_stall only when the output is full.

module quaternion_from_axis_angle_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  qfaa_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output qfaa_pkg::t_out_req o_out_req
);

    localparam int CB = qfaa_pkg::COMPONENT_BITS;
    localparam int F  = qfaa_pkg::FRAC_BITS;
    localparam int RW = qfaa_pkg::RAW_W;
    localparam int MW = qfaa_pkg::MAG_W;

    logic en;
    logic r_out_valid;

    // pipeline advances unless a finished result is held
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // ---------------- stage 1: split signs
    logic                r_s1_vld;
    logic [15:0]         r_s1_xs, r_s1_xc;
    logic                r_s1_ang_neg;
    logic [2:0][CB-1:0]  r_s1_amag;
    logic [2:0]          r_s1_aneg;

    logic [15:0]         n_s1_a;
    logic [2:0][CB-1:0]  n_s1_ax;

    always_comb begin
        n_s1_a = i_in_req.turn_angle[15] ? (~i_in_req.turn_angle + 16'd1)
                                         : i_in_req.turn_angle;
        n_s1_ax[0] = i_in_req.axis_x;
        n_s1_ax[1] = i_in_req.axis_y;
        n_s1_ax[2] = i_in_req.axis_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_xs      <= n_s1_a;
            r_s1_xc      <= qfaa_pkg::Q15_ONE - n_s1_a;
            r_s1_ang_neg <= i_in_req.turn_angle[15];
            for (int i = 0; i < 3; i++) begin
                r_s1_aneg[i] <= n_s1_ax[i][CB-1];
                r_s1_amag[i] <= n_s1_ax[i][CB-1] ? (~n_s1_ax[i] + CB'(1)) : n_s1_ax[i];
            end
        end
    end

    // ---------------- stages 2 to 5: sine polynomial for sin and cos lanes
    // lane 0 is sin (x), lane 1 is cos (1 - x)
    logic                r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    logic [1:0][15:0]    r_s2_x, r_s2_x2, r_s3_x, r_s3_x2, r_s4_x;
    logic [1:0][15:0]    r_s3_tb, r_s4_ta, r_s5_sc;
    logic                r_s2_ang_neg, r_s3_ang_neg, r_s4_ang_neg, r_s5_ang_neg;
    logic [2:0][CB-1:0]  r_s2_amag, r_s3_amag, r_s4_amag, r_s5_amag;
    logic [2:0]          r_s2_aneg, r_s3_aneg, r_s4_aneg, r_s5_aneg;

    logic [1:0][15:0]    n_s2_x;
    logic [1:0][15:0]    n_s2_x2, n_s3_tb, n_s4_ta, n_s5_sc;
    logic [1:0][16:0]    s2_r, s3_r, s4_r, s5_r;

    always_comb begin
        n_s2_x[0] = r_s1_xs;
        n_s2_x[1] = r_s1_xc;
        for (int i = 0; i < 2; i++) begin
            s2_r[i]    = qfaa_pkg::rnd15(32'(n_s2_x[i]) * 32'(n_s2_x[i]));
            n_s2_x2[i] = s2_r[i][15:0];
            s3_r[i]    = qfaa_pkg::rnd15(32'(qfaa_pkg::POLY_C) * 32'(r_s2_x2[i]));
            n_s3_tb[i] = qfaa_pkg::POLY_B - s3_r[i][15:0];
            s4_r[i]    = qfaa_pkg::rnd15(32'(r_s3_tb[i]) * 32'(r_s3_x2[i]));
            n_s4_ta[i] = qfaa_pkg::POLY_A - s4_r[i][15:0];
            s5_r[i]    = qfaa_pkg::rnd15(32'(r_s4_ta[i]) * 32'(r_s4_x[i]));
            n_s5_sc[i] = s5_r[i][15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_x       <= n_s2_x;
            r_s2_x2      <= n_s2_x2;
            r_s3_x       <= r_s2_x;
            r_s3_x2      <= r_s2_x2;
            r_s3_tb      <= n_s3_tb;
            r_s4_x       <= r_s3_x;
            r_s4_ta      <= n_s4_ta;
            r_s5_sc      <= n_s5_sc;
            r_s2_ang_neg <= r_s1_ang_neg;
            r_s3_ang_neg <= r_s2_ang_neg;
            r_s4_ang_neg <= r_s3_ang_neg;
            r_s5_ang_neg <= r_s4_ang_neg;
            r_s2_amag    <= r_s1_amag;
            r_s3_amag    <= r_s2_amag;
            r_s4_amag    <= r_s3_amag;
            r_s5_amag    <= r_s4_amag;
            r_s2_aneg    <= r_s1_aneg;
            r_s3_aneg    <= r_s2_aneg;
            r_s4_aneg    <= r_s3_aneg;
            r_s5_aneg    <= r_s4_aneg;
        end
    end

    // ---------------- stage 6: raw components, units of 2^-(F+15)
    logic                r_s6_vld;
    logic [3:0][RW-1:0]  r_s6_raw;
    logic [2:0]          r_s6_neg;

    logic [3:0][RW-1:0]  n_s6_raw;
    logic [2:0]          n_s6_neg;
    logic [2:0][CB+15:0] s6_prod;

    always_comb begin
        n_s6_raw[0] = RW'(r_s5_sc[1]) << F;
        for (int i = 0; i < 3; i++) begin
            s6_prod[i]    = (CB+16)'(r_s5_amag[i]) * (CB+16)'(r_s5_sc[0]);
            n_s6_raw[i+1] = s6_prod[i][RW-1:0];
            // a vector part of zero keeps a positive sign
            n_s6_neg[i]   = (r_s5_aneg[i] != r_s5_ang_neg) && (s6_prod[i] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (en) begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_raw <= n_s6_raw;
            r_s6_neg <= n_s6_neg;
        end
    end

    // ---------------- stage 7: common right shift so all parts fit 31 bits
    logic                r_s7_vld;
    logic [3:0][MW-1:0]  r_s7_mag;
    logic [2:0]          r_s7_neg;

    logic [RW-1:0]            s7_or;
    logic [qfaa_pkg::SH_W-1:0] s7_sh;
    logic [3:0][MW-1:0]       n_s7_mag;

    always_comb begin
        s7_or = r_s6_raw[0] | r_s6_raw[1] | r_s6_raw[2] | r_s6_raw[3];
        s7_sh = '0;
        for (int k = 1; k <= RW - 31; k++) begin
            if (s7_or[30+k]) begin
                s7_sh = qfaa_pkg::SH_W'(k);
            end
        end
        for (int i = 0; i < 4; i++) begin
            n_s7_mag[i] = MW'(r_s6_raw[i] >> s7_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else if (en) begin
            r_s7_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_mag <= n_s7_mag;
            r_s7_neg <= r_s6_neg;
        end
    end

    // ---------------- stages 8 and 9: squares, then their sum
    logic                               r_s8_vld, r_s9_vld;
    logic [3:0][qfaa_pkg::SQ_W-1:0]     r_s8_sq;
    logic [3:0][MW-1:0]                 r_s8_mag, r_s9_mag;
    logic [2:0]                         r_s8_neg, r_s9_neg;
    logic [qfaa_pkg::SUM_W-1:0]         r_s9_sum;

    logic [3:0][qfaa_pkg::SQ_W-1:0]     n_s8_sq;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_s8_sq[i] = qfaa_pkg::SQ_W'(r_s7_mag[i]) * qfaa_pkg::SQ_W'(r_s7_mag[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld <= 1'b0;
            r_s9_vld <= 1'b0;
        end else if (en) begin
            r_s8_vld <= r_s7_vld;
            r_s9_vld <= r_s8_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_sq  <= n_s8_sq;
            r_s8_mag <= r_s7_mag;
            r_s8_neg <= r_s7_neg;
            r_s9_sum <= qfaa_pkg::SUM_W'(r_s8_sq[0]) + qfaa_pkg::SUM_W'(r_s8_sq[1])
                      + qfaa_pkg::SUM_W'(r_s8_sq[2]) + qfaa_pkg::SUM_W'(r_s8_sq[3]);
            r_s9_mag <= r_s8_mag;
            r_s9_neg <= r_s8_neg;
        end
    end

    // ---------------- magnitude
    qfaa_pkg::t_sqrt_side          sq_side_in, sq_side_out;
    logic                          sq_vld;
    logic [qfaa_pkg::ROOT_W-1:0]   sq_root;

    assign sq_side_in.ctl.neg = r_s9_neg;
    assign sq_side_in.mag     = r_s9_mag;

    qfaa_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s9_vld),
        .i_sum   (r_s9_sum),
        .i_side  (sq_side_in),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side_out)
    );

    // ---------------- divide every part by the magnitude
    logic                              dv_vld;
    logic [3:0][qfaa_pkg::Q_W-1:0]     dv_quo;
    logic                              dv_zero;
    qfaa_pkg::t_div_side               dv_side;

    qfaa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_root  (sq_root),
        .i_mag   (sq_side_out.mag),
        .i_side  (sq_side_out.ctl),
        .o_vld   (dv_vld),
        .o_quo   (dv_quo),
        .o_zero  (dv_zero),
        .o_side  (dv_side)
    );

    // ---------------- output register: sign, zero magnitude case
    qfaa_pkg::t_out_req   r_out_req;
    logic [3:0][CB-1:0]   n_part;
    logic [3:0]           n_neg;

    always_comb begin
        n_neg = {dv_side.neg, 1'b0};
        for (int i = 0; i < 4; i++) begin
            n_part[i] = CB'(dv_quo[i]);
            if (dv_zero) begin
                n_part[i] = '0;
            end else if (n_neg[i]) begin
                n_part[i] = ~n_part[i] + CB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_req.quat_w         <= n_part[0];
            r_out_req.quat_x         <= n_part[1];
            r_out_req.quat_y         <= n_part[2];
            r_out_req.quat_z         <= n_part[3];
            r_out_req.zero_magnitude <= dv_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

endmodule

/* design/qfaa_isqrt.sv */
// qfaa_isqrt: pipelined floor square root, one result bit per stage
// depends on qfaa_pkg
`timescale 1ns / 1ps

module qfaa_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic [qfaa_pkg::SUM_W-1:0]    i_sum,
    input  qfaa_pkg::t_sqrt_side          i_side,
    output logic                          o_vld,
    output logic [qfaa_pkg::ROOT_W-1:0]   o_root,
    output qfaa_pkg::t_sqrt_side          o_side
);

    localparam int N = qfaa_pkg::ROOT_W;

    logic                          r_vld  [0:N-1];
    logic [qfaa_pkg::SUM_W-1:0]    r_rad  [0:N-1];
    logic [qfaa_pkg::RS_W-1:0]     r_rem  [0:N-1];
    logic [N-1:0]                  r_root [0:N-1];
    qfaa_pkg::t_sqrt_side          r_side [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_step
        logic                       vld_in;
        logic [qfaa_pkg::SUM_W-1:0] rad_in;
        logic [qfaa_pkg::RS_W-1:0]  rem_in;
        logic [N-1:0]               root_in;
        qfaa_pkg::t_sqrt_side       side_in;
        logic [qfaa_pkg::RS_W-1:0]  rem2;
        logic [qfaa_pkg::RS_W-1:0]  trial;
        logic                       ge;
        logic [qfaa_pkg::SUM_W-1:0] n_rad;
        logic [qfaa_pkg::RS_W-1:0]  n_rem;
        logic [N-1:0]               n_root;

        if (k == 0) begin : g_first
            assign vld_in  = i_vld;
            assign rad_in  = i_sum;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign rad_in  = r_rad[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign side_in = r_side[k-1];
        end

        // bring down two radicand bits, try (root << 2) | 1
        always_comb begin
            rem2   = {rem_in[qfaa_pkg::RS_W-3:0], rad_in[qfaa_pkg::SUM_W-1 -: 2]};
            trial  = {root_in, 2'b01};
            ge     = (rem2 >= trial);
            n_rem  = ge ? (rem2 - trial) : rem2;
            n_root = {root_in[N-2:0], ge};
            n_rad  = {rad_in[qfaa_pkg::SUM_W-3:0], 2'b00};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= n_rad;
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_root[N-1];
    assign o_side = r_side[N-1];

endmodule

/* design/qfaa_div.sv */
// qfaa_div: four-lane pipelined restoring divider, rounded quotient c * 2^(F+1) + r over 2r
// depends on qfaa_pkg
`timescale 1ns / 1ps

module qfaa_div (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_en,
    input  logic                                   i_vld,
    input  logic [qfaa_pkg::ROOT_W-1:0]            i_root,
    input  logic [3:0][qfaa_pkg::MAG_W-1:0]        i_mag,
    input  qfaa_pkg::t_div_side                    i_side,
    output logic                                   o_vld,
    output logic [3:0][qfaa_pkg::Q_W-1:0]          o_quo,
    output logic                                   o_zero,
    output qfaa_pkg::t_div_side                    o_side
);

    localparam int QW = qfaa_pkg::Q_W;
    localparam int RW = qfaa_pkg::RS_W;
    localparam int F  = qfaa_pkg::FRAC_BITS;

    // setup stage
    logic                          r_p_vld;
    logic [RW-1:0]                 r_p_den;
    logic                          r_p_zero;
    qfaa_pkg::t_div_side           r_p_side;
    logic [3:0][RW-1:0]            r_p_rem;
    logic [3:0][F:0]               r_p_low;

    logic [3:0][qfaa_pkg::NUM_W-1:0] n_num;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_num[i] = {i_mag[i], {(F+1){1'b0}}}
                     + qfaa_pkg::NUM_W'(i_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (i_en) begin
            r_p_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_den  <= RW'({i_root, 1'b0});
            r_p_zero <= (i_root == '0);
            r_p_side <= i_side;
            for (int i = 0; i < 4; i++) begin
                r_p_rem[i] <= RW'(n_num[i] >> (F+1));
                r_p_low[i] <= n_num[i][F:0];
            end
        end
    end

    // one quotient bit per stage
    logic                  r_vld  [0:QW-1];
    logic [RW-1:0]         r_den  [0:QW-1];
    logic                  r_zero [0:QW-1];
    qfaa_pkg::t_div_side   r_side [0:QW-1];
    logic [3:0][RW-1:0]    r_rem  [0:QW-1];
    logic [3:0][F:0]       r_low  [0:QW-1];
    logic [3:0][QW-1:0]    r_quo  [0:QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic                 vld_in;
        logic [RW-1:0]        den_in;
        logic                 zero_in;
        qfaa_pkg::t_div_side  side_in;
        logic [3:0][RW-1:0]   rem_in;
        logic [3:0][F:0]      low_in;
        logic [3:0][QW-1:0]   quo_in;
        logic [3:0][RW-1:0]   n_rem;
        logic [3:0][F:0]      n_low;
        logic [3:0][QW-1:0]   n_quo;

        if (k == 0) begin : g_first
            assign vld_in  = r_p_vld;
            assign den_in  = r_p_den;
            assign zero_in = r_p_zero;
            assign side_in = r_p_side;
            assign rem_in  = r_p_rem;
            assign low_in  = r_p_low;
            assign quo_in  = '0;
        end else begin : g_next
            assign vld_in  = r_vld[k-1];
            assign den_in  = r_den[k-1];
            assign zero_in = r_zero[k-1];
            assign side_in = r_side[k-1];
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign quo_in  = r_quo[k-1];
        end

        always_comb begin
            logic [RW-1:0] rem2;
            logic          ge;
            for (int i = 0; i < 4; i++) begin
                rem2     = {rem_in[i][RW-2:0], low_in[i][F]};
                ge       = (rem2 >= den_in);
                n_rem[i] = ge ? (rem2 - den_in) : rem2;
                n_quo[i] = {quo_in[i][QW-2:0], ge};
                n_low[i] = {low_in[i][F-1:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= den_in;
                r_zero[k] <= zero_in;
                r_side[k] <= side_in;
                r_rem[k]  <= n_rem;
                r_low[k]  <= n_low;
                r_quo[k]  <= n_quo;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_quo  = r_quo[QW-1];
    assign o_zero = r_zero[QW-1];
    assign o_side = r_side[QW-1];

endmodule

/* dv/quaternion_from_axis_angle_core_test.sv */
// quaternion_from_axis_angle_core_test: self-checking bench for the axis/angle quaternion core
// depends on qfaa_pkg and quaternion_from_axis_angle_core; predicts every result in fixed point
`timescale 1ns / 1ps

module quaternion_from_axis_angle_core_test;

    localparam int N_RANDOM    = 1100;
    localparam int LATENCY     = 58;
    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    qfaa_pkg::t_in_req  i_in_req;
    logic               o_out_valid;
    logic               i_out_stall;
    qfaa_pkg::t_out_req o_out_req;

    quaternion_from_axis_angle_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_req  (o_out_req)
    );

    // directed row: request plus an optional typed-in answer
    typedef struct {
        qfaa_pkg::t_in_req  req;
        bit                 known;
        qfaa_pkg::t_out_req ans;
    } t_row;

    qfaa_pkg::t_out_req pending_quats[$];
    int                 fail_count;
    int                 cycle_count = 0;
    bit                 long_hold;

    // 12 ns clock
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // sin(x*pi/2) as an odd quintic, all in Q15
    function automatic longint unsigned quintic_sine(input longint unsigned x);
        longint unsigned x2, t;
        x2 = (x * x + 16384) >> 15;
        t  = (64'd2320 * x2 + 16384) >> 15;
        t  = 64'd21024 - t;
        t  = (t * x2 + 16384) >> 15;
        t  = 64'd51472 - t;
        return (t * x + 16384) >> 15;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n  -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // normalised quaternion for one axis/angle request
    function automatic qfaa_pkg::t_out_req predict_quat(input qfaa_pkg::t_in_req r);
        qfaa_pkg::t_out_req q;
        longint unsigned    mag [4];
        bit                 neg [4];
        longint unsigned    a, s, c, maxv, sum, root, d;
        longint             comp;
        bit                 ang_neg;
        int                 len, sh;
        ang_neg = r.turn_angle[qfaa_pkg::ANGLE_BITS-1];
        a = ang_neg ? longint'(-int'(r.turn_angle)) : longint'(r.turn_angle);
        s = quintic_sine(a);
        c = quintic_sine(32768 - a);
        mag[0] = c << qfaa_pkg::FRAC_BITS;
        neg[0] = 1'b0;
        for (int i = 0; i < 3; i++) begin
            case (i)
                0: comp = r.axis_x;
                1: comp = r.axis_y;
                default: comp = r.axis_z;
            endcase
            mag[i+1] = longint'(comp < 0 ? -comp : comp) * s;
            neg[i+1] = ((comp < 0) != ang_neg) && mag[i+1] != 0;
        end
        maxv = 0;
        foreach (mag[i]) if (mag[i] > maxv) maxv = mag[i];
        len = 0;
        while (len < 64 && (maxv >> len) != 0) len++;
        sh  = (len > 31) ? len - 31 : 0;
        sum = 0;
        foreach (mag[i]) begin
            mag[i] >>= sh;
            sum += mag[i] * mag[i];
        end
        root = int_sqrt(sum);
        q = '0;
        if (root == 0) begin
            q.zero_magnitude = 1'b1;
            return q;
        end
        for (int i = 0; i < 4; i++) begin
            d = ((mag[i] << (qfaa_pkg::FRAC_BITS + 1)) + root) / (2 * root);
            if (neg[i]) d = -d;
            case (i)
                0: q.quat_w = d[qfaa_pkg::COMPONENT_BITS-1:0];
                1: q.quat_x = d[qfaa_pkg::COMPONENT_BITS-1:0];
                2: q.quat_y = d[qfaa_pkg::COMPONENT_BITS-1:0];
                default: q.quat_z = d[qfaa_pkg::COMPONENT_BITS-1:0];
            endcase
        end
        return q;
    endfunction

    function automatic t_row mk_row(input int ax, ay, az, ang, input bit known = 0,
                                    input int w = 0, x = 0, y = 0, z = 0, input bit zm = 0);
        t_row r;
        r.req   = '{axis_x: ax[15:0], axis_y: ay[15:0], axis_z: az[15:0],
                    turn_angle: ang[15:0]};
        r.known = known;
        r.ans   = '{quat_w: w[15:0], quat_x: x[15:0], quat_y: y[15:0], quat_z: z[15:0],
                    zero_magnitude: zm};
        return r;
    endfunction

    // offer one request at the falling edge and hold it until taken
    task automatic send_request(input qfaa_pkg::t_in_req r, input bit known,
                                input qfaa_pkg::t_out_req ans);
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        do @(posedge i_clk); while (o_in_stall);
        // the typed-in answer must agree with the predictor too
        if (known && predict_quat(r) !== ans) begin
            $error("table answer disagrees for %h: table %h predictor %h",
                   r, ans, predict_quat(r));
            fail_count++;
        end
        pending_quats.push_back(predict_quat(r));
        @(negedge i_clk);
    endtask

    task automatic idle_gap(input int n);
        i_in_valid <= 1'b0;
        i_in_req   <= '{axis_x: 16'($urandom), axis_y: 16'($urandom),
                        axis_z: 16'($urandom), turn_angle: 16'($urandom)};
        repeat (n) @(negedge i_clk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 32768) - 16384);
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: own stall pattern, one long hold-off to fill the pipe
    initial begin
        int mode;
        bit hold_done;
        i_out_stall = 1'b0;
        hold_done   = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (long_hold && !hold_done) begin
                hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (3 * LATENCY) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                mode = (cycle_count / 300) % 4;
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 1) == 0);
                    default: i_out_stall <= ($urandom_range(0, 9) < 8);
                endcase
            end
        end
    end

    // result checker at the rising edge
    always @(posedge i_clk) begin
        qfaa_pkg::t_out_req exp_q;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_quats.size() == 0) begin
                $error("unexpected result %h", o_out_req);
                fail_count++;
            end else begin
                exp_q = pending_quats.pop_front();
                if (o_out_req.quat_w !== exp_q.quat_w) begin
                    $error("quat_w expected %0d actual %0d", exp_q.quat_w, o_out_req.quat_w);
                    fail_count++;
                end
                if (o_out_req.quat_x !== exp_q.quat_x) begin
                    $error("quat_x expected %0d actual %0d", exp_q.quat_x, o_out_req.quat_x);
                    fail_count++;
                end
                if (o_out_req.quat_y !== exp_q.quat_y) begin
                    $error("quat_y expected %0d actual %0d", exp_q.quat_y, o_out_req.quat_y);
                    fail_count++;
                end
                if (o_out_req.quat_z !== exp_q.quat_z) begin
                    $error("quat_z expected %0d actual %0d", exp_q.quat_z, o_out_req.quat_z);
                    fail_count++;
                end
                if (o_out_req.zero_magnitude !== exp_q.zero_magnitude) begin
                    $error("zero_magnitude expected %0b actual %0b",
                           exp_q.zero_magnitude, o_out_req.zero_magnitude);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_row               rows [$];
        qfaa_pkg::t_in_req  r;
        qfaa_pkg::t_out_req none;
        int                 burst;
        fail_count  = 0;
        long_hold   = 1'b0;
        none        = '0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero angle: identity quaternion whatever the axis
        rows.push_back(mk_row(0, 0, 0, 0, 1, 16384, 0, 0, 0, 0));
        rows.push_back(mk_row(16384, 0, 0, 0, 1, 16384, 0, 0, 0, 0));
        // half turn with zero axis: magnitude zero, all parts forced to zero
        rows.push_back(mk_row(0, 0, 0, -32768, 1, 0, 0, 0, 0, 1));
        // half turn about unit axes: pure vector
        rows.push_back(mk_row(16384, 0, 0, -32768, 1, 0, -16384, 0, 0, 0));
        rows.push_back(mk_row(0, -16384, 0, -32768, 1, 0, 0, 16384, 0, 0));
        rows.push_back(mk_row(0, 0, 32767, -32768, 1, 0, 0, 0, -16384, 0));
        // field extremes and sign mixes, checked by the predictor
        rows.push_back(mk_row(-32768, -32768, -32768, 32767));
        rows.push_back(mk_row(32767, 32767, 32767, 32767));
        rows.push_back(mk_row(32767, -32768, 1, -32767));
        rows.push_back(mk_row(-1, -1, -1, 1));
        rows.push_back(mk_row(1, 0, 0, -1));
        rows.push_back(mk_row(0, 0, 0, 16384));
        rows.push_back(mk_row(16384, 16384, 16384, 16384));
        rows.push_back(mk_row(-16384, 16384, -16384, -16384));
        rows.push_back(mk_row(11585, 11585, 0, 8192));
        rows.push_back(mk_row(-32768, 0, 0, 1));
        rows.push_back(mk_row(0, 32767, 0, -16384));
        rows.push_back(mk_row(1, 1, 1, 32767));
        foreach (rows[i]) send_request(rows[i].req, rows[i].known, rows[i].ans);

        // random bursts with random gaps
        for (int n = 0; n < N_RANDOM; ) begin
            if (n >= N_RANDOM / 2) long_hold = 1'b1;
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                r = '{axis_x: rand_field(), axis_y: rand_field(),
                      axis_z: rand_field(), turn_angle: rand_field()};
                send_request(r, 1'b0, none);
            end
            if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 20));
        end
        i_in_valid <= 1'b0;

        while (pending_quats.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
